### hdl/rud_pkg.sv
// ============================================================================
// Restoring divider package
// Shared word type, pipeline depth and the record that travels down the
// pipeline of the restoring unsigned divider.
// ============================================================================
package rud_pkg;

  // Operand width; one pipeline stage resolves one quotient bit.
  localparam int unsigned WordBits   = 32;
  localparam int unsigned StageCount = WordBits;

  typedef logic [WordBits-1:0] word_t;

  // Per-stage payload. num_quo starts as the dividend; each stage shifts the
  // next dividend bit out at the top and the new quotient bit in at the bottom,
  // so after the last stage it holds the quotient.
  typedef struct packed {
    word_t num_quo;
    word_t rem;
    word_t den;
    logic  dbz;
  } rud_stage_t;

endpackage : rud_pkg

### hdl/rud_if.sv
// ============================================================================
// Restoring divider channels
// Valid/ready channels for the operand pair and for the division result.
// ============================================================================
interface rud_req_if;
  import rud_pkg::*;

  logic  valid;
  logic  ready;
  word_t dividend;
  word_t divisor;

  modport source (output valid, output dividend, output divisor, input ready);
  modport sink   (input valid, input dividend, input divisor, output ready);
endinterface : rud_req_if

interface rud_rsp_if;
  import rud_pkg::*;

  logic  valid;
  logic  ready;
  word_t quotient;
  word_t remainder;
  logic  div_by_zero;

  modport source (output valid, output quotient, output remainder, output div_by_zero,
                  input ready);
  modport sink   (input valid, input quotient, input remainder, input div_by_zero,
                  output ready);
endinterface : rud_rsp_if

### hdl/rud_stage.sv
// ============================================================================
// Restoring divider stage
// One registered step of restoring division: shift in the next dividend bit,
// subtract the divisor when it fits and record the quotient bit.
// ============================================================================
module rud_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               adv_i,
  input  logic               valid_i,
  input  rud_pkg::rud_stage_t stage_i,
  output logic               valid_o,
  output rud_pkg::rud_stage_t stage_o
);
  import rud_pkg::*;

  logic          valid_q;
  rud_stage_t    stage_d;
  rud_stage_t    stage_q;
  logic          carry;
  word_t         shifted;
  logic [WordBits:0] diff;
  logic          fit;

  // Shift the partial remainder and try the subtraction. A bit carried out of
  // the top means the divisor always fits.
  always_comb begin
    carry   = stage_i.rem[WordBits-1];
    shifted = {stage_i.rem[WordBits-2:0], stage_i.num_quo[WordBits-1]};
    diff    = {1'b0, shifted} - {1'b0, stage_i.den};
    fit     = carry | ~diff[WordBits];

    stage_d         = stage_i;
    stage_d.rem     = fit ? diff[WordBits-1:0] : shifted;
    stage_d.num_quo = {stage_i.num_quo[WordBits-2:0], fit};
  end

  // Valid bit is control state and is reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (adv_i) begin
      valid_q <= valid_i;
    end
  end

  // Payload register, loaded only with a live transaction.
  always_ff @(posedge clk_i) begin
    if (adv_i && valid_i) begin
      stage_q <= stage_d;
    end
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule : rud_stage

### hdl/restoring_unsigned_divider.sv
// ============================================================================
// Restoring unsigned divider
// Pipelined 32-bit unsigned division giving quotient, remainder and a
// divide-by-zero flag, one quotient bit per pipeline stage.
// ============================================================================
//
//  Channel  Direction  Payload                                Transaction
//  -------  ---------  -------------------------------------  -----------------
//  req_i    in         dividend[31:0], divisor[31:0]          valid & ready
//  rsp_o    out        quotient, remainder, div_by_zero       valid & ready
//
//  Each accepted request passes through the 32-stage subtract-and-compare
//  chain, which resolves one quotient bit per stage, to give its result.
//  A new request is accepted every cycle while the result side keeps up.
//  The whole pipeline advances together: when a result waits unaccepted, every
//  stage holds, and req_i.ready drops, so nothing is lost or repeated.
//  Reset clears all stage valid bits; payload registers are not reset.
//
module restoring_unsigned_divider (
  input  logic      clk_i,
  input  logic      rst_ni,
  rud_req_if.sink   req_i,
  rud_rsp_if.source rsp_o
);
  import rud_pkg::*;

  logic       adv;
  logic       valid   [StageCount+1];
  rud_stage_t stage   [StageCount+1];

  // The pipeline moves when the output register is empty or being emptied.
  assign adv         = ~valid[StageCount] | rsp_o.ready;
  assign req_i.ready = adv;

  // Entry record: the partial remainder starts at zero.
  assign valid[0] = req_i.valid;
  assign stage[0] = '{num_quo: req_i.dividend,
                      rem:     '0,
                      den:     req_i.divisor,
                      dbz:     (req_i.divisor == '0)};

  // One stage per quotient bit, most significant first.
  for (genvar g = 0; g < StageCount; g++) begin : g_stage
    rud_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .adv_i   (adv),
      .valid_i (valid[g]),
      .stage_i (stage[g]),
      .valid_o (valid[g+1]),
      .stage_o (stage[g+1])
    );
  end

  // The last stage doubles as the output register; a zero divisor forces
  // zero quotient and remainder.
  assign rsp_o.valid       = valid[StageCount];
  assign rsp_o.quotient    = stage[StageCount].dbz ? '0 : stage[StageCount].num_quo;
  assign rsp_o.remainder   = stage[StageCount].dbz ? '0 : stage[StageCount].rem;
  assign rsp_o.div_by_zero = stage[StageCount].dbz;

  // A finished division with a non-zero divisor leaves a remainder below it.
  a_rem_below_den : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid[StageCount] && !stage[StageCount].dbz |->
      stage[StageCount].rem < stage[StageCount].den)
    else $error("remainder not below divisor");

  // The flag travels with its own divisor.
  a_dbz_matches : assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid[StageCount] |-> stage[StageCount].dbz == (stage[StageCount].den == '0))
    else $error("divide-by-zero flag does not match divisor");

  // When the pipeline holds, the output record and its valid bit hold too.
  a_hold_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> valid[StageCount] && $stable(stage[StageCount]))
    else $error("output stage changed while stalled");

  // A request is refused only while a result waits.
  a_ready_rule : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !req_i.ready |-> rsp_o.valid && !rsp_o.ready)
    else $error("request refused without a waiting result");

endmodule : restoring_unsigned_divider
